FILE: design/slcdf_pkg.sv
`default_nettype none

package slcdf_pkg;

   localparam logic [7:0] SyncFirst  = 8'hEB;
   localparam logic [7:0] SyncSecond = 8'h90;

   // header is bytes 0..6, byte 6 carries the checksum
   localparam int unsigned HeaderBytes = 7;
   localparam logic [8:0]  CsumPos     = 9'(HeaderBytes - 1);
   localparam logic [7:0]  MinLength   = 8'(HeaderBytes - 1);

   // receiver phase codes
   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_HELD    = 2'd2;

   // action codes
   localparam logic ACT_BYTE  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // result status codes
   localparam logic [3:0] ST_DISCARD   = 4'd0;
   localparam logic [3:0] ST_HEADER    = 4'd1;
   localparam logic [3:0] ST_HEADER_OK = 4'd2;
   localparam logic [3:0] ST_CSUM_ERR  = 4'd3;
   localparam logic [3:0] ST_PAYLOAD   = 4'd4;
   localparam logic [3:0] ST_DONE      = 4'd5;
   localparam logic [3:0] ST_IGNORED   = 4'd6;
   localparam logic [3:0] ST_CLEARED   = 4'd7;
   localparam logic [3:0] ST_BAD_LEN   = 4'd8;

   typedef struct packed {
      logic [3:0] status;
      logic [7:0] data_byte;
      logic [7:0] byte_position;
      logic [7:0] frame_length;
   } result_type;

endpackage

`default_nettype wire

FILE: design/sync_length_checksum_deframer.sv
`default_nettype none

// Byte-stream deframer. Each request beat is either a received byte or a
// clear. The block hunts for the sync pair EB 90, gathers a seven-byte
// header whose byte 2 is the length field (total frame bytes minus one) and
// whose byte 6 is the modulo-256 sum of bytes 0..5, then passes on
// (length - 6) payload bytes and holds, ignoring bytes, until a clear beat
// rearms it. Every request beat yields exactly one response beat carrying a
// status, the echoed byte, its frame position and the captured length.
// Throughput is one beat per clock while req_stall is low: the frame state is
// updated in the cycle a beat is taken, and the response goes into a two-deep
// output buffer, so req_stall only rises when both response slots are full;
// it follows the skid slot alone, whether or not rsp_stall holds the head.
module sync_length_checksum_deframer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_action,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_status,
   output logic [7:0]      rsp_data_byte,
   output logic [7:0]      rsp_byte_position,
   output logic [7:0]      rsp_frame_length
);
   import slcdf_pkg::*;

   // frame state
   logic [1:0] phase_ff,    phase_in;
   logic [8:0] position_ff, position_in;
   logic [7:0] length_ff,   length_in;
   logic [7:0] sum_ff,      sum_in;

   // response buffer: head register plus one skid slot
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic       req_accept;
   logic       rsp_accept;
   result_type res;
   logic [7:0] sum_add;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = head_valid_ff && !rsp_stall;
   assign sum_add    = sum_ff + req_rx_byte;

   // Work out the response for the beat on the request port and the state
   // it leaves behind. State only advances when the beat is taken.
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      res         = '{status: ST_IGNORED, data_byte: req_rx_byte,
                      byte_position: position_ff[7:0], frame_length: length_ff};

      if (req_action == ACT_CLEAR) begin
         // rearm from any phase
         phase_in    = PH_HUNT;
         position_in = '0;
         length_in   = '0;
         sum_in      = '0;
         res         = '{status: ST_CLEARED, data_byte: 8'd0,
                         byte_position: 8'd0, frame_length: 8'd0};
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (position_ff == 9'd0) begin
                  res.status = ST_DISCARD;
                  if (req_rx_byte == SyncFirst) begin
                     res.status  = ST_HEADER;
                     sum_in      = req_rx_byte;
                     position_in = 9'd1;
                  end
               end else if (position_ff == 9'd1) begin
                  if (req_rx_byte == SyncSecond) begin
                     res.status  = ST_HEADER;
                     sum_in      = sum_add;
                     position_in = 9'd2;
                  end else begin
                     // wrong second sync byte: drop it, do not retry as first
                     res.status  = ST_DISCARD;
                     position_in = '0;
                     length_in   = '0;
                     sum_in      = '0;
                  end
               end else if (position_ff < CsumPos) begin
                  if (position_ff == 9'd2) begin
                     length_in        = req_rx_byte;
                     res.frame_length = req_rx_byte;
                  end
                  res.status  = ST_HEADER;
                  sum_in      = sum_add;
                  position_in = position_ff + 9'd1;
               end else begin
                  // checksum byte; checksum is judged before length
                  res.byte_position = CsumPos[7:0];
                  if (req_rx_byte != sum_ff) begin
                     res.status  = ST_CSUM_ERR;
                     position_in = '0;
                     length_in   = '0;
                     sum_in      = '0;
                  end else if (length_ff < MinLength) begin
                     res.status  = ST_BAD_LEN;
                     position_in = '0;
                     length_in   = '0;
                     sum_in      = '0;
                  end else if (length_ff == MinLength) begin
                     // no payload: frame ends on the header
                     res.status  = ST_DONE;
                     position_in = 9'(HeaderBytes);
                     phase_in    = PH_HELD;
                  end else begin
                     res.status  = ST_HEADER_OK;
                     position_in = 9'(HeaderBytes);
                     phase_in    = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (position_ff >= {1'b0, length_ff}) begin
                  res.status        = ST_DONE;
                  res.byte_position = length_ff;
                  phase_in          = PH_HELD;
                  position_in       = {1'b0, length_ff} + 9'd1;
               end else begin
                  res.status  = ST_PAYLOAD;
                  position_in = position_ff + 9'd1;
               end
            end
            default: begin
               // held (and the unused code): ignore the byte
               res.status = ST_IGNORED;
            end
         endcase
      end
   end

   // Response buffer: fill the head first, spill into the skid slot while
   // the head is stalled, and refill the head from the skid slot on a pop.
   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;

      if (rsp_accept) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_in       = res;
            head_valid_in = req_accept;
         end
      end else if (req_accept) begin
         if (!head_valid_ff) begin
            head_in       = res;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         position_ff   <= '0;
         length_ff     <= '0;
         sum_ff        <= '0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff    <= phase_in;
            position_ff <= position_in;
            length_ff   <= length_in;
            sum_ff      <= sum_in;
         end
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = head_valid_ff;
   assign rsp_status        = head_ff.status;
   assign rsp_data_byte     = head_ff.data_byte;
   assign rsp_byte_position = head_ff.byte_position;
   assign rsp_frame_length  = head_ff.frame_length;

   // the skid slot is only ever occupied behind a full head
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid slot full while head empty");

   // a taken clear beat rearms the receiver
   a_clear_rearms: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ACT_CLEAR) |=>
         (phase_ff == PH_HUNT && position_ff == 9'd0 && length_ff == 8'd0))
      else $error("clear did not rearm the receiver");

   // while taking payload the position stays between the header and length
   a_payload_window: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |->
         (position_ff >= 9'(HeaderBytes) && position_ff <= {1'b0, length_ff}))
      else $error("payload position outside frame");

   // after a taken beat the head always holds a response the next cycle (that beat or an older one)
   a_beat_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> head_valid_ff)
      else $error("accepted beat produced no response");

   // a stalled head response is held
   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (head_valid_ff && rsp_stall) |=> (head_valid_ff && $stable(head_ff)))
      else $error("stalled response changed");

endmodule

`default_nettype wire
